// ----- rtl/record_sector_fixup_check_core_assert.svh -----
// assertion macros for the record sector fixup check rtl
`ifndef RECORD_SECTOR_FIXUP_CHECK_CORE_ASSERT_SVH
`define RECORD_SECTOR_FIXUP_CHECK_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RSFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rsfc_pkg.sv -----
// types and constants for the record sector fixup check
`default_nettype none

package rsfc_pkg;

    // record geometry
    localparam int MAX_RECORD_BYTES   = 4096;
    localparam int SECTOR_BYTES       = 512;
    localparam int HEADER_BYTES       = 48;
    localparam int RESET_RECORD_BYTES = 1024;

    // field widths
    localparam int WORD_W = 16;
    localparam int CFG_W  = 13;

    // derived widths
    localparam int LEN_W       = $clog2(MAX_RECORD_BYTES) + 1;
    localparam int POS_W       = $clog2(MAX_RECORD_BYTES / 2);
    localparam int OFF_W       = $clog2(MAX_RECORD_BYTES);
    localparam int SEC_WORD_W  = $clog2(SECTOR_BYTES / 2);
    localparam int SEC_SHIFT   = $clog2(SECTOR_BYTES);
    localparam int STORE_DEPTH = MAX_RECORD_BYTES / SECTOR_BYTES;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 2);

    // signature words ("FI" and "LE" little-endian)
    localparam logic [WORD_W-1:0] SIG_WORD0 = 16'h4946;
    localparam logic [WORD_W-1:0] SIG_WORD1 = 16'h454C;

    // header word positions
    localparam logic [POS_W-1:0] POS_SIG0  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SIG1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_OFF   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_COUNT = POS_W'(3);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SIGNATURE = 3'd1,
        ST_OFFSET    = 3'd2,
        ST_PAST_END  = 3'd3,
        ST_COUNT     = 3'd4,
        ST_MISMATCH  = 3'd5,
        ST_LATE      = 3'd6
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_status           status;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/rsfc_engine.sv -----
// per-word header check, replacement store and sector-end fixup
`default_nettype none

module rsfc_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_take,
    input  wire logic [rsfc_pkg::WORD_W-1:0] i_word,
    input  wire logic [rsfc_pkg::LEN_W-1:0]  i_len,
    output rsfc_pkg::t_result               o_res
);
    import rsfc_pkg::*;

    `include "record_sector_fixup_check_core_assert.svh"

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [OFF_W-1:0]  r_off,   n_off;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [WORD_W-1:0] r_check, n_check;
    t_status           r_err,   n_err;
    logic [WORD_W-1:0] r_store [STORE_DEPTH];

    logic [LEN_W-2:0]        len_half;
    logic [LEN_W-SEC_SHIFT-1:0] sec_cnt;
    logic                    last;
    logic [POS_W-1:0]        off_word;
    logic [POS_W:0]          arr_end_word;
    logic [IDX_W-1:0]        wr_idx;
    logic [IDX_W-1:0]        sec_idx;
    logic                    sec_last;
    logic                    store_we;
    logic [WORD_W-1:0]       repl_word;
    logic [WORD_W-1:0]       res_word;
    t_status                 err_upd;

    // record geometry from the length register
    assign len_half   = i_len[LEN_W-1:1];
    assign sec_cnt    = i_len[LEN_W-1:SEC_SHIFT];
    assign last       = ({1'b0, r_pos} + (POS_W+1)'(1)) >= len_half;

    // array and sector positions in words
    assign off_word     = r_off[OFF_W-1:1];
    assign arr_end_word = {1'b0, off_word} + (POS_W+1)'(r_cnt);
    assign wr_idx       = IDX_W'(r_pos - off_word - POS_W'(1));
    assign sec_idx      = r_pos[POS_W-1:SEC_WORD_W];
    assign sec_last     = &r_pos[SEC_WORD_W-1:0];

    // replacement read, forwarding a same-cycle write
    assign repl_word = (store_we && (wr_idx == sec_idx)) ? i_word : r_store[sec_idx];

    // header checks and fixup for the current word
    always_comb begin
        n_off    = r_off;
        n_cnt    = r_cnt;
        n_check  = r_check;
        err_upd  = r_err;
        store_we = 1'b0;
        res_word = i_word;
        if (r_err == ST_OK) begin
            if (r_pos == POS_SIG0) begin
                if (i_word != SIG_WORD0) err_upd = ST_SIGNATURE;
            end else if (r_pos == POS_SIG1) begin
                if (i_word != SIG_WORD1) err_upd = ST_SIGNATURE;
            end else if (r_pos == POS_OFF) begin
                if ((i_word < WORD_W'(HEADER_BYTES)) || (i_word >= WORD_W'(i_len)) ||
                    i_word[0]) begin
                    err_upd = ST_OFFSET;
                end else begin
                    n_off = i_word[OFF_W-1:0];
                end
            end else if (r_pos == POS_COUNT) begin
                if ((18'(r_off) + {1'b0, i_word, 1'b0}) > 18'(i_len)) begin
                    err_upd = ST_PAST_END;
                end else if ((i_word < WORD_W'(2)) ||
                             (i_word > (WORD_W'(sec_cnt) + WORD_W'(1)))) begin
                    err_upd = ST_COUNT;
                end else begin
                    n_cnt = i_word[CNT_W-1:0];
                end
            end else begin
                // capture check value and replacements
                if (r_pos == off_word) begin
                    n_check = i_word;
                end else if ((r_pos > off_word) && ({1'b0, r_pos} < arr_end_word)) begin
                    store_we = 1'b1;
                end
                // sector-end compare and swap
                if (sec_last && ((CNT_W'(sec_idx) + CNT_W'(1)) < r_cnt)) begin
                    if (({1'b0, off_word} + (POS_W+1)'(sec_idx) + (POS_W+1)'(1)) >
                        {1'b0, r_pos}) begin
                        err_upd = ST_LATE;
                    end else if (i_word != r_check) begin
                        err_upd = ST_MISMATCH;
                    end else begin
                        res_word = repl_word;
                    end
                end
            end
        end
        // record end clears the per-record state
        if (last) begin
            n_pos   = '0;
            n_off   = '0;
            n_cnt   = '0;
            n_check = '0;
            n_err   = ST_OK;
        end else begin
            n_pos   = r_pos + POS_W'(1);
            n_err   = err_upd;
        end
    end

    // result for the current word
    always_comb begin
        o_res.word   = res_word;
        o_res.status = last ? err_upd : ST_OK;
        o_res.last   = last;
    end

    // record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_off   <= '0;
            r_cnt   <= '0;
            r_check <= '0;
            r_err   <= ST_OK;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_off   <= n_off;
            r_cnt   <= n_cnt;
            r_check <= n_check;
            r_err   <= n_err;
        end
    end

    // replacement store, written before it is read within a record
    always_ff @(posedge i_clk) begin
        if (i_take && store_we) begin
            r_store[wr_idx] <= i_word;
        end
    end

    `RSFC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_take && o_res.last,
        (r_pos == '0) && (r_err == ST_OK), "record state not cleared after last word")
    `RSFC_ASSERT_NEXT(a_pos_steps, i_clk, i_rst_n, i_take && !o_res.last,
        r_pos == POS_W'($past(r_pos) + POS_W'(1)), "word position did not advance")
    `RSFC_ASSERT_SAME(a_swap_at_sector_end, i_clk, i_rst_n, i_take && (o_res.word != i_word),
        (r_err == ST_OK) && sec_last, "word replaced outside a clean sector end")
    `RSFC_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n,
        i_take && (r_err != ST_OK) && !o_res.last,
        r_err == $past(r_err), "error code changed within a record")

endmodule

`default_nettype wire

// ----- rtl/record_sector_fixup_check_core.sv -----
// Record sector fixup check: one 16-bit record word per request.
// A result appears on o_valid in the cycle after its request is accepted.
// One word per cycle while o_stall is low; the header check and sector-end swap form one stage.
// The output register frees its slot in the cycle its result is taken.
// Reset clears the record state and sets the length register to 1024 bytes;
// the replacement store is not cleared.
`default_nettype none

module record_sector_fixup_check_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [rsfc_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [rsfc_pkg::WORD_W-1:0] i_word_in,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [rsfc_pkg::WORD_W-1:0]      o_word_out,
    output logic [2:0]                       o_status,
    output logic                             o_last_out
);
    import rsfc_pkg::*;

    logic [LEN_W-1:0] r_len, n_len;
    logic [CFG_W-1:0] cfg_even;
    logic             take;
    t_result          res;
    t_result          r_out;
    logic             r_out_valid, n_out_valid;

    // effective record length, saturated at write time
    always_comb begin
        cfg_even = {i_cfg_wr_data[CFG_W-1:1], 1'b0};
        if (LEN_W'(cfg_even) < LEN_W'(SECTOR_BYTES)) begin
            n_len = LEN_W'(SECTOR_BYTES);
        end else if (LEN_W'(cfg_even) > LEN_W'(MAX_RECORD_BYTES)) begin
            n_len = LEN_W'(MAX_RECORD_BYTES);
        end else begin
            n_len = LEN_W'(cfg_even);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(RESET_RECORD_BYTES);
        end else if (i_cfg_wr_en) begin
            r_len <= n_len;
        end
    end

    // accept while the output slot is empty or being drained
    assign o_stall = r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;

    rsfc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (i_word_in),
        .i_len   (r_len),
        .o_res   (res)
    );

    // output register
    assign n_out_valid = take || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_word_out = r_out.word;
    assign o_status   = r_out.status;
    assign o_last_out = r_out.last;

endmodule

`default_nettype wire
